// ===== rtl/core/dssd_pkg.sv =====
package dssd_pkg;

   // Digits per display side
   localparam int DIGIT_COUNT = 3;

   // Column counter width; at least one bit so a one-digit build still has a counter
   localparam int COL_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   // Common width for comparing the column against the 2-bit dot registers
   localparam int CMP_W = (COL_W > 2) ? COL_W : 2;

   localparam int VALUE_W     = 16;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 29;

   localparam int TABLE_DEPTH = 12;
   localparam int DOT_INDEX   = 10;

   localparam logic [7:0] GLYPH_P = 8'(159 - 16);
   localparam logic [7:0] GLYPH_O = 8'd212;

   localparam logic [7:0] LEFT_TABLE [TABLE_DEPTH] = '{
      8'd95, 8'd65, 8'd157, 8'd217, 8'd195, 8'd218,
      8'd222, 8'd73, 8'd223, 8'd219, 8'd32, 8'd0
   };
   localparam logic [7:0] RIGHT_TABLE [TABLE_DEPTH] = '{
      8'd219, 8'd24, 8'd179, 8'd186, 8'd120, 8'd234,
      8'd235, 8'd152, 8'd251, 8'd250, 8'd4, 8'd0
   };

   typedef logic [3:0] digit_type;
   typedef logic [7:0] segment_type;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_SET_LEFT  = 2'd1,
      OP_SET_RIGHT = 2'd2,
      OP_SHOW_PO   = 2'd3
   } operation_type;

   // CSR register indexes, decoded from the word address
   typedef enum logic {
      CSR_LEFT_DOT  = 1'b0,
      CSR_RIGHT_DOT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] right_segments;
      logic [7:0] left_segments;
      logic [1:0] active_column;
   } rsp_payload_type;

   // 10 to the power n, evaluated at elaboration
   function automatic longint unsigned pow10(input int n);
      longint unsigned acc;
      acc = 1;
      for (int k = 0; k < n; k++) begin
         acc = acc * 10;
      end
      return acc;
   endfunction

endpackage

// ===== rtl/core/dssd_bcd_split.sv =====
module dssd_bcd_split
   import dssd_pkg::*;
(
   input  logic [VALUE_W-1:0] value,
   output digit_type          digits [DIGIT_COUNT]   // index 0 is the ones digit
);

   // quot[i] = value / 10^i, quot[0] = value
   logic [VALUE_W-1:0] quot [DIGIT_COUNT+1];

   assign quot[0] = value;

   for (genvar i = 1; i <= DIGIT_COUNT; i++) begin : g_quot
      localparam longint unsigned DIV = pow10(i);
      if (DIV > longint'(2**VALUE_W - 1)) begin : g_zero
         assign quot[i] = '0;
      end else begin : g_recip
         // ceil(2^32 / DIV); exact for any 16-bit value since error * value < 2^32
         localparam longint unsigned RECIP =
            ((longint'(1) << RECIP_SHIFT) + DIV - 1) / DIV;
         logic [VALUE_W+RECIP_W-1:0] prod;
         assign prod    = VALUE_W'(value) * RECIP_W'(RECIP);
         assign quot[i] = VALUE_W'(prod >> RECIP_SHIFT);
      end
   end

   for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_digit
      logic [VALUE_W-1:0] rem;
      // quot[i] - 10 * quot[i+1], shift-add form
      assign rem       = quot[i] - ((quot[i+1] << 3) + (quot[i+1] << 1));
      assign digits[i] = rem[3:0];
   end

endmodule

// ===== rtl/core/dual_seven_segment_scan_driver.sv =====
// Dual three-digit seven-segment scan driver.
//
// Requests arrive on req_* (valid/stall, accepted when req_valid is high and
// req_stall is low). A set-left or set-right request stores the low decimal
// digits of value as segment patterns for that side; show-PO loads the "P"
// and "O" glyphs into the left side. These produce no response. A tick
// request advances the scan column (wrapping at the digit count) and emits
// one response on rsp_* with both sides' segment bytes for the new column,
// decimal point merged in, and the enabled column index.
//
// Timing: a request is held in the input register, where the digit split and
// table lookups run; a tick response then moves into the output register,
// which drives rsp_valid. One request per cycle is taken while req_stall is
// low; the rate is set by the single input/output register pair.
// When rsp_stall holds a response, set requests still drain; a tick waits in
// the input register and req_stall rises until the output register frees.
// Reset (synchronous, active high) blanks both stores, sets column 0, and
// sets both dot registers to 3 (no dot). Dot registers are written over the
// csr_* APB port at byte addresses 0 (left) and 4 (right).
module dual_seven_segment_scan_driver
   import dssd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,

   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,

   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,

   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   // ---------------- CSRs ----------------
   logic [1:0] left_dot_ff,  left_dot_in;
   logic [1:0] right_dot_ff, right_dot_in;
   logic       csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_comb begin
      left_dot_in  = left_dot_ff;
      right_dot_in = right_dot_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LEFT_DOT:  left_dot_in  = csr_pwdata[1:0];
            CSR_RIGHT_DOT: right_dot_in = csr_pwdata[1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_LEFT_DOT:  csr_prdata = {30'd0, left_dot_ff};
         CSR_RIGHT_DOT: csr_prdata = {30'd0, right_dot_ff};
      endcase
   end

   // ---------------- input register ----------------
   logic               in_valid_ff, in_valid_in;
   operation_type      in_op_ff;
   logic [VALUE_W-1:0] in_value_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_accept;
   logic               out_free;
   logic               is_tick;
   logic               advance;

   assign is_tick    = (in_op_ff == OP_TICK);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // set/PO requests never need the output register
   assign advance    = in_valid_ff && (!is_tick || out_free);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // ---------------- digit stores and scan ----------------
   digit_type   digits [DIGIT_COUNT];
   segment_type left_store_ff  [DIGIT_COUNT];
   segment_type left_store_in  [DIGIT_COUNT];
   segment_type right_store_ff [DIGIT_COUNT];
   segment_type right_store_in [DIGIT_COUNT];
   logic [COL_W-1:0] scan_ff, scan_in, next_col;

   dssd_bcd_split u_bcd_split (
      .value  (in_value_ff),
      .digits (digits)
   );

   assign next_col = (scan_ff == COL_W'(DIGIT_COUNT - 1)) ? '0 : scan_ff + 1'b1;

   always_comb begin
      left_store_in  = left_store_ff;
      right_store_in = right_store_ff;
      scan_in        = scan_ff;
      if (advance) begin
         unique case (in_op_ff)
            OP_TICK: begin
               scan_in = next_col;
            end
            OP_SET_LEFT: begin
               // column 0 is the most significant digit
               for (int c = 0; c < DIGIT_COUNT; c++) begin
                  left_store_in[c] = LEFT_TABLE[digits[DIGIT_COUNT-1-c]];
               end
            end
            OP_SET_RIGHT: begin
               for (int c = 0; c < DIGIT_COUNT; c++) begin
                  right_store_in[c] = RIGHT_TABLE[digits[DIGIT_COUNT-1-c]];
               end
            end
            OP_SHOW_PO: begin
               for (int c = 0; c < DIGIT_COUNT; c++) begin
                  left_store_in[c] = '0;
               end
               left_store_in[0] = GLYPH_P;
               if (DIGIT_COUNT > 1) begin
                  left_store_in[1 % DIGIT_COUNT] = GLYPH_O;
               end
            end
         endcase
      end
   end

   // ---------------- output register ----------------
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   segment_type     left_seg, right_seg;

   always_comb begin
      left_seg  = left_store_ff[next_col];
      right_seg = right_store_ff[next_col];
      if (CMP_W'(next_col) == CMP_W'(left_dot_ff)) begin
         left_seg = left_seg | LEFT_TABLE[DOT_INDEX];
      end
      if (CMP_W'(next_col) == CMP_W'(right_dot_ff)) begin
         right_seg = right_seg | RIGHT_TABLE[DOT_INDEX];
      end
   end

   always_comb begin
      rsp_payload_in                = rsp_payload_ff;
      rsp_valid_in                  = rsp_valid_ff;
      if (advance && is_tick) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.right_segments = right_seg;
         rsp_payload_in.left_segments  = left_seg;
         rsp_payload_in.active_column  = 2'(next_col);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         left_dot_ff  <= 2'd3;
         right_dot_ff <= 2'd3;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         for (int c = 0; c < DIGIT_COUNT; c++) begin
            left_store_ff[c]  <= '0;
            right_store_ff[c] <= '0;
         end
      end else begin
         left_dot_ff    <= left_dot_in;
         right_dot_ff   <= right_dot_in;
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         scan_ff        <= scan_in;
         left_store_ff  <= left_store_in;
         right_store_ff <= right_store_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff    <= operation_type'(req_payload.operation);
         in_value_ff <= req_payload.value;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   // ---------------- assertions ----------------
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      scan_ff < COL_W'(DIGIT_COUNT))
      else $error("scan column out of range");

   a_stall_needs_held_request: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && is_tick && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked tick");

   a_tick_gives_response: assert property (@(posedge clock) disable iff (reset)
      (advance && is_tick) |=> (rsp_valid_ff && rsp_payload_ff.active_column == 2'(scan_ff)))
      else $error("tick did not load matching response");

   a_set_keeps_scan: assert property (@(posedge clock) disable iff (reset)
      (advance && !is_tick) |=> (scan_ff == $past(scan_ff)))
      else $error("set request moved scan column");

endmodule
